// ----- rtl/core/vwvp_pkg.sv -----
// shared constants and types for the vertex world / view-projection transform
`timescale 1ns / 1ps
package vwvp_pkg;

    localparam int FIELD_WIDTH     = 32;
    localparam int REG_WIDTH       = 64;
    localparam int SLOT_WIDTH      = 16;
    localparam int NUM_ROWS        = 4;
    localparam int NUM_REGS        = 8;
    localparam int REG_IDX_WIDTH   = 3;
    localparam int CFG_ADDR_WIDTH  = 6;
    localparam int ADDR_LSB        = 3;
    localparam int FRAC_COEF       = 12;
    localparam int ONE_COORD       = 65536;
    localparam int ONE_COEF        = 4096;
    localparam int PIPE_DEPTH      = 6;
    localparam int DEF_COORD_WIDTH = 32;
    localparam int DEF_COEF_WIDTH  = 16;

    typedef struct packed {
        logic mul;
        logic sum;
        logic sat;
    } stage_en_t;

endpackage

// ----- rtl/core/vertex_world_view_projection_transform_core.sv -----
// top level: config registers, pipeline control and the two transform stages
//
// usage: one vertex position (s_model_x/y/z, signed Q16.16) is taken per
// word on the s_ channel. the block returns the world position (x, y, z)
// and the clip-space position (x, y, z, w) as one word on the m_ channel.
// the world and view-projection matrices are written over the apb port,
// 64 bits per row, register i at byte address 8*i. the user must write
// them only while idle; the block itself does not enforce it.
// the pipeline has 6 register stages, with 3 register stages per
// matrix product: multiply, add, shift and clamp.
// throughput: one word per cycle; every stage has its own valid bit, so
// a stalled m_ready only stops stages that are full and bubbles still
// close up; s_ready stays high while any stage ahead has room.
// reset: all valid bits clear, both matrices return to identity.
// when the receiver stalls the output word holds and the pipeline fills
// behind it; nothing is dropped or repeated.
`timescale 1ns / 1ps
module vertex_world_view_projection_transform_core #(
    parameter int COORD_WIDTH = vwvp_pkg::DEF_COORD_WIDTH,
    parameter int COEF_WIDTH  = vwvp_pkg::DEF_COEF_WIDTH
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [vwvp_pkg::CFG_ADDR_WIDTH-1:0]   paddr,
    input  logic [vwvp_pkg::REG_WIDTH-1:0]        pwdata,
    output logic [vwvp_pkg::REG_WIDTH-1:0]        prdata,
    output logic                                  pready,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic [vwvp_pkg::FIELD_WIDTH-1:0]      s_model_x,
    input  logic [vwvp_pkg::FIELD_WIDTH-1:0]      s_model_y,
    input  logic [vwvp_pkg::FIELD_WIDTH-1:0]      s_model_z,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic [vwvp_pkg::FIELD_WIDTH-1:0]      m_world_x,
    output logic [vwvp_pkg::FIELD_WIDTH-1:0]      m_world_y,
    output logic [vwvp_pkg::FIELD_WIDTH-1:0]      m_world_z,
    output logic [vwvp_pkg::FIELD_WIDTH-1:0]      m_clip_x,
    output logic [vwvp_pkg::FIELD_WIDTH-1:0]      m_clip_y,
    output logic [vwvp_pkg::FIELD_WIDTH-1:0]      m_clip_z,
    output logic [vwvp_pkg::FIELD_WIDTH-1:0]      m_clip_w
);

    localparam int VEC_WIDTH  = (COORD_WIDTH > 17) ? COORD_WIDTH : 18;
    localparam int WORLD_DLY  = vwvp_pkg::PIPE_DEPTH / 2;
    localparam int NR         = vwvp_pkg::NUM_ROWS;

    logic [vwvp_pkg::REG_WIDTH-1:0]        cfg_reg [vwvp_pkg::NUM_REGS];
    logic [vwvp_pkg::REG_IDX_WIDTH-1:0]    cfg_idx;
    logic                                  cfg_wr;

    logic [vwvp_pkg::PIPE_DEPTH-1:0]       vld_reg;
    logic [vwvp_pkg::PIPE_DEPTH-1:0]       vld_next;
    logic [vwvp_pkg::PIPE_DEPTH-1:0]       load;

    vwvp_pkg::stage_en_t                   en_world;
    vwvp_pkg::stage_en_t                   en_clip;

    logic [NR-1:0][vwvp_pkg::REG_WIDTH-1:0] world_rows;
    logic [NR-1:0][vwvp_pkg::REG_WIDTH-1:0] clip_rows;
    logic [NR-1:0][VEC_WIDTH-1:0]           model_vec;
    logic [NR-1:0][VEC_WIDTH-1:0]           world_vec;
    logic [NR-1:0][COORD_WIDTH-1:0]         world_res;
    logic [NR-1:0][COORD_WIDTH-1:0]         clip_res;
    logic [NR-2:0][COORD_WIDTH-1:0]         world_reg [WORLD_DLY];

    // apb register file
    assign pready  = 1'b1;
    assign cfg_idx = paddr[vwvp_pkg::ADDR_LSB +: vwvp_pkg::REG_IDX_WIDTH];
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign prdata  = cfg_reg[cfg_idx];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int r = 0; r < NR; r++) begin
                cfg_reg[r]      <= vwvp_pkg::REG_WIDTH'(vwvp_pkg::ONE_COEF)
                                   << (vwvp_pkg::SLOT_WIDTH * r);
                cfg_reg[r + NR] <= vwvp_pkg::REG_WIDTH'(vwvp_pkg::ONE_COEF)
                                   << (vwvp_pkg::SLOT_WIDTH * r);
            end
        end else if (cfg_wr) begin
            cfg_reg[cfg_idx] <= pwdata;
        end
    end

    always_comb begin
        for (int r = 0; r < NR; r++) begin
            world_rows[r] = cfg_reg[r];
            clip_rows[r]  = cfg_reg[r + NR];
        end
    end

    // stage flow control
    always_comb begin
        load[vwvp_pkg::PIPE_DEPTH-1] = !vld_reg[vwvp_pkg::PIPE_DEPTH-1] || m_ready;
        for (int i = vwvp_pkg::PIPE_DEPTH - 2; i >= 0; i--) begin
            load[i] = !vld_reg[i] || load[i+1];
        end
        vld_next[0] = s_valid;
        for (int i = 1; i < vwvp_pkg::PIPE_DEPTH; i++) begin
            vld_next[i] = vld_reg[i-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            for (int i = 0; i < vwvp_pkg::PIPE_DEPTH; i++) begin
                if (load[i]) begin
                    vld_reg[i] <= vld_next[i];
                end
            end
        end
    end

    assign s_ready  = load[0];
    assign m_valid  = vld_reg[vwvp_pkg::PIPE_DEPTH-1];
    assign en_world = '{mul: load[0], sum: load[1], sat: load[2]};
    assign en_clip  = '{mul: load[3], sum: load[4], sat: load[5]};

    // homogeneous model position, w = 1.0
    assign model_vec[0] = VEC_WIDTH'($signed(s_model_x[COORD_WIDTH-1:0]));
    assign model_vec[1] = VEC_WIDTH'($signed(s_model_y[COORD_WIDTH-1:0]));
    assign model_vec[2] = VEC_WIDTH'($signed(s_model_z[COORD_WIDTH-1:0]));
    assign model_vec[3] = VEC_WIDTH'(vwvp_pkg::ONE_COORD);

    vwvp_mat_vec #(
        .COORD_WIDTH (COORD_WIDTH),
        .COEF_WIDTH  (COEF_WIDTH),
        .VEC_WIDTH   (VEC_WIDTH)
    ) u_world (
        .aclk    (aclk),
        .en      (en_world),
        .rows    (world_rows),
        .vec_in  (model_vec),
        .vec_out (world_res)
    );

    always_comb begin
        for (int c = 0; c < NR; c++) begin
            world_vec[c] = VEC_WIDTH'($signed(world_res[c]));
        end
    end

    vwvp_mat_vec #(
        .COORD_WIDTH (COORD_WIDTH),
        .COEF_WIDTH  (COEF_WIDTH),
        .VEC_WIDTH   (VEC_WIDTH)
    ) u_clip (
        .aclk    (aclk),
        .en      (en_clip),
        .rows    (clip_rows),
        .vec_in  (world_vec),
        .vec_out (clip_res)
    );

    // world position rides alongside the second product
    always_ff @(posedge aclk) begin
        if (load[WORLD_DLY]) begin
            world_reg[0] <= world_res[NR-2:0];
        end
        for (int k = 1; k < WORLD_DLY; k++) begin
            if (load[WORLD_DLY + k]) begin
                world_reg[k] <= world_reg[k-1];
            end
        end
    end

    assign m_world_x = vwvp_pkg::FIELD_WIDTH'($signed(world_reg[WORLD_DLY-1][0]));
    assign m_world_y = vwvp_pkg::FIELD_WIDTH'($signed(world_reg[WORLD_DLY-1][1]));
    assign m_world_z = vwvp_pkg::FIELD_WIDTH'($signed(world_reg[WORLD_DLY-1][2]));
    assign m_clip_x  = vwvp_pkg::FIELD_WIDTH'($signed(clip_res[0]));
    assign m_clip_y  = vwvp_pkg::FIELD_WIDTH'($signed(clip_res[1]));
    assign m_clip_z  = vwvp_pkg::FIELD_WIDTH'($signed(clip_res[2]));
    assign m_clip_w  = vwvp_pkg::FIELD_WIDTH'($signed(clip_res[3]));

    a_ready_when_out_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled with empty output stage");

    a_full_stall_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        (&vld_reg && !m_ready) |-> !s_ready)
        else $error("input accepted into a full stalled pipeline");

    a_accept_fills_first_stage: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> vld_reg[0])
        else $error("accepted word lost at first stage");

endmodule

// ----- rtl/core/vwvp_mat_vec.sv -----
// three-stage 4x4 matrix by vector product with floor shift and saturation
`timescale 1ns / 1ps
module vwvp_mat_vec #(
    parameter int COORD_WIDTH = vwvp_pkg::DEF_COORD_WIDTH,
    parameter int COEF_WIDTH  = vwvp_pkg::DEF_COEF_WIDTH,
    parameter int VEC_WIDTH   = vwvp_pkg::DEF_COORD_WIDTH
) (
    input  logic                                                   aclk,
    input  vwvp_pkg::stage_en_t                                    en,
    input  logic [vwvp_pkg::NUM_ROWS-1:0][vwvp_pkg::REG_WIDTH-1:0] rows,
    input  logic [vwvp_pkg::NUM_ROWS-1:0][VEC_WIDTH-1:0]           vec_in,
    output logic [vwvp_pkg::NUM_ROWS-1:0][COORD_WIDTH-1:0]         vec_out
);

    localparam int PROD_WIDTH = COEF_WIDTH + VEC_WIDTH;
    localparam int SUM_WIDTH  = PROD_WIDTH + 2;
    localparam logic signed [SUM_WIDTH-1:0] COORD_MAX =
        {{(SUM_WIDTH - COORD_WIDTH + 1){1'b0}}, {(COORD_WIDTH - 1){1'b1}}};
    localparam logic signed [SUM_WIDTH-1:0] COORD_MIN = ~COORD_MAX;

    logic signed [PROD_WIDTH-1:0] prod_reg  [vwvp_pkg::NUM_ROWS][vwvp_pkg::NUM_ROWS];
    logic signed [PROD_WIDTH-1:0] prod_next [vwvp_pkg::NUM_ROWS][vwvp_pkg::NUM_ROWS];
    logic signed [SUM_WIDTH-1:0]  sum_reg   [vwvp_pkg::NUM_ROWS];
    logic signed [SUM_WIDTH-1:0]  sum_next  [vwvp_pkg::NUM_ROWS];
    logic signed [SUM_WIDTH-1:0]  shifted   [vwvp_pkg::NUM_ROWS];
    logic [vwvp_pkg::NUM_ROWS-1:0][COORD_WIDTH-1:0] out_reg;
    logic [vwvp_pkg::NUM_ROWS-1:0][COORD_WIDTH-1:0] out_next;

    always_comb begin
        for (int r = 0; r < vwvp_pkg::NUM_ROWS; r++) begin
            for (int c = 0; c < vwvp_pkg::NUM_ROWS; c++) begin
                prod_next[r][c] =
                    $signed(rows[r][vwvp_pkg::SLOT_WIDTH*c +: COEF_WIDTH])
                    * $signed(vec_in[c]);
            end
        end
    end

    always_comb begin
        for (int r = 0; r < vwvp_pkg::NUM_ROWS; r++) begin
            sum_next[r] = SUM_WIDTH'(prod_reg[r][0]) + SUM_WIDTH'(prod_reg[r][1])
                        + SUM_WIDTH'(prod_reg[r][2]) + SUM_WIDTH'(prod_reg[r][3]);
        end
    end

    // floor shift, then clamp to the coordinate range
    always_comb begin
        for (int r = 0; r < vwvp_pkg::NUM_ROWS; r++) begin
            shifted[r] = sum_reg[r] >>> vwvp_pkg::FRAC_COEF;
            if (shifted[r] > COORD_MAX) begin
                out_next[r] = COORD_MAX[COORD_WIDTH-1:0];
            end else if (shifted[r] < COORD_MIN) begin
                out_next[r] = COORD_MIN[COORD_WIDTH-1:0];
            end else begin
                out_next[r] = shifted[r][COORD_WIDTH-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en.mul) begin
            prod_reg <= prod_next;
        end
        if (en.sum) begin
            sum_reg <= sum_next;
        end
        if (en.sat) begin
            out_reg <= out_next;
        end
    end

    assign vec_out = out_reg;

endmodule
